@@ rtl/core/b2d_pkg.sv @@
// Shared constants for the binary to decimal ASCII converter.
package b2d_pkg;

   // Width of the binary input value.
   localparam int VALUE_W = 32;

   // Input bits consumed by the digit cells in one conversion step.
   localparam int STEP_BITS = 4;

   // Conversion steps needed to shift the whole value through the cells.
   localparam int CONV_STEPS = VALUE_W / STEP_BITS;

   // Step counter width, wide enough to hold CONV_STEPS itself.
   localparam int CNT_W = $clog2(CONV_STEPS + 1);

   // Width of one BCD digit.
   localparam int BCD_W = 4;

   // Width of an output character code.
   localparam int CHAR_W = 6;

   // ASCII code of the character zero.
   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

   // Default number of decimal positions.
   localparam int DEF_MAX_DIGITS = 10;

endpackage : b2d_pkg

@@ rtl/core/b2d_ifs.sv @@
// Valid/ready channel interfaces for the converter's input and result streams.
interface b2d_req_if;
   logic                         valid;
   logic                         ready;
   logic [b2d_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface : b2d_req_if

interface b2d_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [b2d_pkg::CHAR_W-1:0]   digit_char;
   logic                         last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface : b2d_rsp_if

@@ rtl/core/b2d_cell.sv @@
// One BCD digit cell of the shift-and-add-3 conversion chain.
module b2d_cell (
   input  logic                             clock,
   input  logic                             clear,
   input  logic                             step_en,
   input  logic [b2d_pkg::STEP_BITS-1:0]    carry_in,
   output logic [b2d_pkg::STEP_BITS-1:0]    carry_out,
   output logic [b2d_pkg::BCD_W-1:0]        digit
);
   import b2d_pkg::*;

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] work;
   logic [BCD_W-1:0] corr;

   // Each sub-step corrects the digit by 3 when it is 5 or more, then doubles it,
   // shifting in one bit from the lower neighbor and passing the top bit upward.
   always_comb begin
      work      = digit_ff;
      corr      = digit_ff;
      carry_out = '0;
      for (int j = 0; j < STEP_BITS; j++) begin
         corr         = (work >= BCD_W'(5)) ? work + BCD_W'(3) : work;
         carry_out[j] = corr[BCD_W-1];
         work         = {corr[BCD_W-2:0], carry_in[j]};
      end
   end

   // Digit register: cleared when a new value is loaded, advanced on each step.
   always_comb begin
      if (clear) begin
         digit_in = '0;
      end else if (step_en) begin
         digit_in = work;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule : b2d_cell

@@ rtl/core/b2d_conv.sv @@
// Conversion stage: input shifter, step counter and the row of digit cells.
module b2d_conv #(
   parameter int MAX_DIGITS = b2d_pkg::DEF_MAX_DIGITS,
   parameter int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   b2d_req_if.sink                                  req_bus,
   input  logic                                     take,
   output logic                                     done,
   output logic [MAX_DIGITS-1:0][b2d_pkg::BCD_W-1:0] digits,
   output logic [IDX_W-1:0]                         top
);
   import b2d_pkg::*;

   logic                  busy_ff;
   logic                  busy_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic [VALUE_W-1:0]    val_ff;
   logic [VALUE_W-1:0]    val_in;
   logic                  accept;
   logic                  step_en;
   logic [STEP_BITS-1:0]  cell_cin  [MAX_DIGITS];
   logic [STEP_BITS-1:0]  cell_cout [MAX_DIGITS];

   // Handshake: a new value may enter once the previous digits are handed over.
   assign done          = busy_ff && (cnt_ff == CNT_W'(CONV_STEPS));
   assign req_bus.ready = !busy_ff || (done && take);
   assign accept        = req_bus.valid && req_bus.ready;
   assign step_en       = busy_ff && !done;

   // Control and shifter next state.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = req_bus.value;
      end else if (step_en) begin
         cnt_in  = cnt_ff + 1'b1;
         val_in  = val_ff << STEP_BITS;
      end else if (done && take) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   // The lowest cell takes the next input bits, most significant first.
   always_comb begin
      for (int j = 0; j < STEP_BITS; j++) begin
         cell_cin[0][j] = val_ff[VALUE_W-1-j];
      end
   end

   // Row of digit cells, each feeding its carries to the next one up.
   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
      if (g > 0) begin : g_link
         assign cell_cin[g] = cell_cout[g-1];
      end
      b2d_cell u_cell (
         .clock     (clock),
         .clear     (accept),
         .step_en   (step_en),
         .carry_in  (cell_cin[g]),
         .carry_out (cell_cout[g]),
         .digit     (digits[g])
      );
   end

   // Position of the most significant nonzero digit; zero when all are zero.
   always_comb begin
      top = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digits[i] != '0) begin
            top = IDX_W'(i);
         end
      end
   end

endmodule : b2d_conv

@@ rtl/core/b2d_out.sv @@
// Output stage: holds a converted number and sends its characters one per transfer.
module b2d_out #(
   parameter int MAX_DIGITS = b2d_pkg::DEF_MAX_DIGITS,
   parameter int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     done,
   input  logic [MAX_DIGITS-1:0][b2d_pkg::BCD_W-1:0] digits,
   input  logic [IDX_W-1:0]                         top,
   output logic                                     take,
   b2d_rsp_if.source                                rsp_bus
);
   import b2d_pkg::*;

   logic                             valid_ff;
   logic                             valid_in;
   logic [IDX_W-1:0]                 pos_ff;
   logic [IDX_W-1:0]                 pos_in;
   logic [MAX_DIGITS-1:0][BCD_W-1:0] dig_ff;
   logic [MAX_DIGITS-1:0][BCD_W-1:0] dig_in;
   logic                             xfer;
   logic                             at_last;

   assign at_last = (pos_ff == '0);
   assign xfer    = valid_ff && rsp_bus.ready;
   assign take    = done && (!valid_ff || (xfer && at_last));

   // Load a new number or step down one digit per transfer.
   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      dig_in   = dig_ff;
      if (take) begin
         valid_in = 1'b1;
         pos_in   = top;
         dig_in   = digits;
      end else if (xfer) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      dig_ff <= dig_in;
   end

   // Result payload: ASCII code of the current digit and the end mark.
   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.digit_char = ASCII_ZERO + CHAR_W'(dig_ff[pos_ff]);
   assign rsp_bus.last_digit = at_last;

endmodule : b2d_out

@@ rtl/core/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter.
//
//   Channel   Dir   Handshake      Payload
//   req_bus   in    valid/ready    value[31:0], unsigned binary number
//   rsp_bus   out   valid/ready    digit_char[5:0], last_digit
//
// A value runs through the digit cells in eight steps of four bits, then is handed
// to the output register; the next value is accepted in the cycle of that handoff.
// Characters leave one per cycle while rsp_bus is ready.
// Reset is synchronous and clears the busy flag, the step counter and the valid flag.
// A stalled result holds the output stage; conversion of the next value continues
// and waits for the handoff once finished.
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = b2d_pkg::DEF_MAX_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   b2d_req_if.sink     req_bus,
   b2d_rsp_if.source   rsp_bus
);
   import b2d_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic                             take;
   logic                             done;
   logic [MAX_DIGITS-1:0][BCD_W-1:0] digits;
   logic [IDX_W-1:0]                 top;

   // Conversion through the digit cell row.
   b2d_conv #(
      .MAX_DIGITS (MAX_DIGITS),
      .IDX_W      (IDX_W)
   ) u_conv (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .done    (done),
      .digits  (digits),
      .top     (top)
   );

   // Character output with leading zeros skipped.
   b2d_out #(
      .MAX_DIGITS (MAX_DIGITS),
      .IDX_W      (IDX_W)
   ) u_out (
      .clock   (clock),
      .reset   (reset),
      .done    (done),
      .digits  (digits),
      .top     (top),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule : binary_to_decimal_ascii

@@ tb/decimal_text_checker.sv @@
// Checker that predicts and compares the decimal characters of the converter.
module decimal_text_checker #(
   parameter int MAX_DIGITS = b2d_pkg::DEF_MAX_DIGITS
) (
   input  logic  clock,
   input  logic  reset,
   b2d_req_if    req_bus,
   b2d_rsp_if    rsp_bus,
   output int    pending_chars,
   output int    fail_count
);
   import b2d_pkg::*;

   localparam int RADIX = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } digit_char_type;

   // Characters still owed by the block, oldest first.
   digit_char_type expected_chars[$];

   // Splits a value into decimal digits over MAX_DIGITS positions and queues the text,
   // most significant digit first, with leading zeros dropped.
   function automatic void expand_decimal(input logic [VALUE_W-1:0] value);
      int unsigned     digit_at[MAX_DIGITS];
      logic [63:0]     rest;
      int              top;
      digit_char_type  entry;
      rest = 64'(value);
      top = 0;
      for (int n = 0; n < MAX_DIGITS; n++) begin
         digit_at[n] = int'(rest % RADIX);
         rest = rest / RADIX;
         if (digit_at[n] != 0) top = n + 1;
      end
      // A value whose kept digits are all zero prints as a single zero.
      if (top == 0) begin
         entry.code = ASCII_ZERO;
         entry.last = 1'b1;
         expected_chars.push_back(entry);
      end else begin
         for (int k = top - 1; k >= 0; k--) begin
            entry.code = ASCII_ZERO + CHAR_W'(digit_at[k]);
            entry.last = (k == 0);
            expected_chars.push_back(entry);
         end
      end
   endfunction

   initial begin
      fail_count = 0;
      pending_chars = 0;
   end

   // Predict on every input transfer and compare every result transfer.
   always @(posedge clock) begin
      digit_char_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) expand_decimal(req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character: expected none, got char %0d last %0b",
                        $time, rsp_bus.digit_char, rsp_bus.last_digit);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_bus.digit_char !== want.code) begin
                  $display("%0t: digit_char mismatch: expected %0d, got %0d",
                           $time, want.code, rsp_bus.digit_char);
                  fail_count++;
               end
               if (rsp_bus.last_digit !== want.last) begin
                  $display("%0t: last_digit mismatch: expected %0b, got %0b",
                           $time, want.last, rsp_bus.last_digit);
                  fail_count++;
               end
            end
         end
      end
      pending_chars = expected_chars.size();
   end

endmodule : decimal_text_checker

@@ tb/binary_to_decimal_ascii_tb.sv @@
// Testbench top for the binary to decimal ASCII converter: stimulus, stalls and verdict.
module binary_to_decimal_ascii_tb #(
   parameter int MAX_DIGITS = b2d_pkg::DEF_MAX_DIGITS
);
   import b2d_pkg::*;

   localparam int PERIOD         = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 148;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   logic clock = 1'b0;
   logic reset;
   int   pending_chars;
   int   fail_count;
   int   sent_count = 0;
   int   directed_count = 0;
   int   idle_cycles = 0;

   b2d_req_if req_bus ();
   b2d_rsp_if rsp_bus ();

   binary_to_decimal_ascii #(.MAX_DIGITS(MAX_DIGITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   decimal_text_checker #(.MAX_DIGITS(MAX_DIGITS)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .pending_chars (pending_chars),
      .fail_count    (fail_count)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: a stall pattern that steps through four modes, plus one long
   // hold-off early in the random part so the block backs up into its input.
   initial begin
      int cyc;
      int mode;
      bit held;
      cyc = 0;
      held = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && directed_count > 0 && sent_count >= directed_count + 10) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         mode = (cyc / 48) % 4;
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= ((cyc % 5) != 0);
         endcase
         cyc++;
      end
   end

   // Input side: directed values, then random values, offered in bursts with gaps.
   initial begin
      logic [VALUE_W-1:0] number_list[$];
      logic [63:0]        wide;
      logic [63:0]        scale;
      int                 idx;
      int                 burst;
      int                 gap;
      int                 n;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;

      // Zero, single digits, carries across powers of ten, interior zeros and the extremes.
      number_list = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                      32'd1000, 32'd100000, 32'd10000001, 32'd999999999,
                      32'd1000000000, 32'd1000000001, 32'd1234567890, 32'd2147483648,
                      32'd3000000003, 32'd4000000000, 32'd4294967290, 32'd4294967295,
                      32'h55555555, 32'hAAAAAAAA};
      directed_count = number_list.size();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // Random digit count with plenty of zeros inside the number.
               n = $urandom_range(1, 10);
               wide = 0;
               for (int d = 0; d < n; d++) begin
                  if (d == 0) wide = wide * 10 + $urandom_range(1, 9);
                  else if ($urandom_range(0, 2) == 0) wide = wide * 10;
                  else wide = wide * 10 + $urandom_range(0, 9);
               end
               number_list.push_back(wide[VALUE_W-1:0]);
            end
            4, 5, 6: number_list.push_back($urandom);
            7: number_list.push_back($urandom_range(0, 1000));
            8: begin
               // Just around a power of ten.
               scale = 1;
               repeat ($urandom_range(0, 9)) scale = scale * 10;
               wide = scale + $urandom_range(0, 2) - 1;
               number_list.push_back(wide[VALUE_W-1:0]);
            end
            default: number_list.push_back(32'hFFFF_FFFF - $urandom_range(0, 1000));
         endcase
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      idx = 0;
      while (idx < number_list.size()) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && idx < number_list.size()) begin
            req_bus.valid <= 1'b1;
            req_bus.value <= number_list[idx];
            @(posedge clock);
            while (!req_bus.ready) @(posedge clock);
            @(negedge clock);
            idx++;
            sent_count = idx;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            req_bus.value <= $urandom;
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid <= 1'b0;

      // Let every owed character arrive, then watch for stray ones.
      wait (pending_chars == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_chars == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule : binary_to_decimal_ascii_tb
